[hw/rtl/mm4_pkg.sv]
// Shared types for the 4x4 fixed-point matrix multiplier.
// Holds the item structs, the action codes and the pipeline tag.
// No dependencies.
package mm4_pkg;

    // Action codes of an input item.
    typedef enum logic [1:0] {
        ACT_WR_LEFT  = 2'd0,
        ACT_WR_RIGHT = 2'd1,
        ACT_MULTIPLY = 2'd2
    } action_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_DRAIN = 2'd2
    } state_t;

    // One input item.
    typedef struct packed {
        action_t            action;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [3:0]         prod_index;
        logic signed [31:0] prod_value;
        logic               saturated;
        logic               last;
    } out_item_t;

    // Tag that travels with each read pair through the pipeline.
    typedef struct packed {
        logic       valid;
        logic       first;   // first of the four products of a dot product
        logic       fin;     // fourth product, the sum is complete after it
        logic [3:0] k;       // product element index
    } mm4_tag_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic adv;           // pipeline advances this cycle
        logic busy;          // products or a finished sum still in flight
    } mm4_stat_t;

endpackage

[hw/rtl/mm4_if.sv]
// Handshake channels of the 4x4 matrix multiplier: input and result.
// Depends on mm4_pkg for the item structs.
interface mm4_in_if
    import mm4_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mm4_out_if
    import mm4_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mm4_store.sv]
// Left and right matrix stores: two 16-entry synchronous memories with
// one write port and one registered read port each. Depends on mm4_pkg.
module mm4_store
    import mm4_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_left,
    input  logic                         wr_right,
    input  logic [3:0]                   wr_addr,
    input  logic signed [ELEM_WIDTH-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [3:0]                   rd_addr_left,
    input  logic [3:0]                   rd_addr_right,
    input  mm4_tag_t                     tag_in,
    output logic signed [ELEM_WIDTH-1:0] rd_left,
    output logic signed [ELEM_WIDTH-1:0] rd_right,
    output mm4_tag_t                     tag_out
);

    logic signed [ELEM_WIDTH-1:0] left_mem  [16];
    logic signed [ELEM_WIDTH-1:0] right_mem [16];
    logic signed [ELEM_WIDTH-1:0] rd_left_reg;
    logic signed [ELEM_WIDTH-1:0] rd_right_reg;
    mm4_tag_t                     tag_reg;

    // Write ports.
    always_ff @(posedge clk)
    begin
        if (wr_left)
        begin
            left_mem[wr_addr] <= wr_data;
        end
        if (wr_right)
        begin
            right_mem[wr_addr] <= wr_data;
        end
    end

    // Read ports; the data holds while the pipeline is stalled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_left_reg  <= left_mem[rd_addr_left];
            rd_right_reg <= right_mem[rd_addr_right];
        end
    end

    // The tag is registered together with the read data, so the two stay aligned.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (rd_en)
        begin
            tag_reg <= tag_in;
        end
    end

    assign rd_left  = rd_left_reg;
    assign rd_right = rd_right_reg;
    assign tag_out  = tag_reg;

endmodule

[hw/rtl/mm4_dot.sv]
// Multiply-accumulate datapath: one product per cycle unless stalled,
// 4-term sum, scaling, saturation, result register. Depends on mm4_pkg.
module mm4_dot
    import mm4_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int ELEM_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [ELEM_WIDTH-1:0] rd_left,
    input  logic signed [ELEM_WIDTH-1:0] rd_right,
    input  mm4_tag_t                     tag_in,
    output mm4_stat_t                    stat,
    mm4_out_if.source                    prod
);

    localparam int PW = 2 * ELEM_WIDTH;
    localparam int AW = PW + 2;

    logic signed [PW-1:0]         prod_reg;
    mm4_tag_t                     ptag_reg;
    logic signed [AW-1:0]         acc_reg;
    logic                         done_reg;
    logic [3:0]                   done_k_reg;
    out_item_t                    out_reg;
    logic                         out_valid_reg;
    logic                         adv;
    logic signed [AW-1:0]         shifted;
    logic [AW-ELEM_WIDTH:0]       upper;
    logic                         fits;
    logic signed [ELEM_WIDTH-1:0] sat_val;
    out_item_t                    out_next;

    // The whole pipeline moves unless a result is waiting and not taken.
    assign adv = !out_valid_reg || prod.ready;

    // Product stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= rd_left * rd_right;
        end
    end

    // Accumulator stage; a new sum starts with its first product.
    always_ff @(posedge clk)
    begin
        if (adv && ptag_reg.valid)
        begin
            if (ptag_reg.first)
            begin
                acc_reg <= AW'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + AW'(prod_reg);
            end
            done_k_reg <= ptag_reg.k;
        end
    end

    // Control of the product and accumulator stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptag_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (adv)
        begin
            ptag_reg <= tag_in;
            done_reg <= ptag_reg.valid && ptag_reg.fin;
        end
    end

    // Scale the finished sum and clip it to the element range.
    always_comb
    begin
        shifted = acc_reg >>> FRAC_BITS;
        upper   = shifted[AW-1:ELEM_WIDTH-1];
        fits    = (&upper) || !(|upper);
        if (fits)
        begin
            sat_val = shifted[ELEM_WIDTH-1:0];
        end
        else if (shifted[AW-1])
        begin
            sat_val = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
        end
        out_next.prod_index = done_k_reg;
        out_next.prod_value = 32'(sat_val);
        out_next.saturated  = !fits;
        out_next.last       = (done_k_reg == 4'hF);
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (adv && done_reg)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= done_reg;
        end
    end

    assign prod.valid = out_valid_reg;
    assign prod.data  = out_reg;
    assign stat.adv   = adv;
    assign stat.busy  = ptag_reg.valid || done_reg;

endmodule

[hw/rtl/matrix4_multiply.sv]
// 4x4 signed fixed-point matrix multiplier, column-major storage.
// Depends on mm4_pkg, mm4_if, mm4_store and mm4_dot.
//
// Usage:
//   cmd carries input items. A left or right write item stores one element
//   at elem_index (column times four plus row) while the block is idle.
//   A multiply item emits the sixteen elements of left times right on prod
//   in column-major order, the sixteenth marked with last.
//   Each element is the sum of four products, shifted right by FRAC_BITS
//   and clipped to ELEM_WIDTH bits, with saturated raised on clipping.
// Timing:
//   The single multiplier takes one product per cycle, from one read of
//   each store, while prod is not stalled. A multiply item occupies the
//   block until its last sum reaches the result register; ready is low
//   meanwhile. Write items are taken back to back at one per cycle while idle.
// Reset and stalls:
//   Reset empties the pipeline and the result register; the store contents
//   are undefined until written. While prod is stalled the whole pipeline,
//   the store reads included, holds. The last result may still wait on
//   prod while the next item is taken.
module matrix4_multiply
    import mm4_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int ELEM_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    mm4_in_if.sink     cmd,
    mm4_out_if.source  prod
);

    state_t                       state_reg;
    state_t                       state_next;
    logic [5:0]                   step_reg;
    logic [5:0]                   step_next;
    logic                         accept;
    logic                         wr_left;
    logic                         wr_right;
    logic                         issue;
    mm4_tag_t                     tag_s0;
    mm4_tag_t                     tag_s1;
    mm4_stat_t                    stat;
    logic signed [ELEM_WIDTH-1:0] rd_left;
    logic signed [ELEM_WIDTH-1:0] rd_right;

    // Items are taken only while no multiply is in flight, so a write never
    // meets a read of the same entry and no forwarding is needed.
    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign wr_left   = accept && (cmd.data.action == ACT_WR_LEFT);
    assign wr_right  = accept && (cmd.data.action == ACT_WR_RIGHT);

    // Step counter is {column, row, term}; term runs fastest.
    assign issue        = (state_reg == ST_RUN);
    assign tag_s0.valid = issue;
    assign tag_s0.first = (step_reg[1:0] == 2'd0);
    assign tag_s0.fin   = (step_reg[1:0] == 2'd3);
    assign tag_s0.k     = step_reg[5:2];

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.data.action == ACT_MULTIPLY))
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (stat.adv)
                begin
                    step_next = step_reg + 6'd1;
                    if (step_reg == 6'h3F)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!tag_s1.valid && !stat.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    mm4_store #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_left       (wr_left),
        .wr_right      (wr_right),
        .wr_addr       (cmd.data.elem_index),
        .wr_data       (cmd.data.elem_value[ELEM_WIDTH-1:0]),
        .rd_en         (stat.adv),
        .rd_addr_left  ({step_reg[1:0], step_reg[3:2]}),
        .rd_addr_right ({step_reg[5:4], step_reg[1:0]}),
        .tag_in        (tag_s0),
        .rd_left       (rd_left),
        .rd_right      (rd_right),
        .tag_out       (tag_s1)
    );

    mm4_dot #(
        .FRAC_BITS  (FRAC_BITS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_left  (rd_left),
        .rd_right (rd_right),
        .tag_in   (tag_s1),
        .stat     (stat),
        .prod     (prod)
    );

    // A multiply item starts the sequence at the first step.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.data.action == ACT_MULTIPLY) |=> state_reg == ST_RUN && step_reg == 6'd0)
        else $error("multiply item did not start the sequence");

    // Back in idle, no product or sum of the previous multiply is in flight.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !tag_s1.valid && !stat.busy)
        else $error("pipeline not empty while idle");

    // The last mark goes with the sixteenth element only.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        prod.valid |-> prod.data.last == (prod.data.prod_index == 4'hF))
        else $error("last mark and element index disagree");

    // A stalled pipeline issues no new step.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && !stat.adv |=> step_reg == $past(step_reg))
        else $error("step counter moved while stalled");

endmodule

[sim/matrix4_multiply_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the 4x4 fixed-point matrix multiplier.
// Loads both matrices, runs directed and random multiply items, checks every product.
// Depends on mm4_pkg, mm4_if and matrix4_multiply.
module matrix4_multiply_tb;
    import mm4_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int ELEM_WIDTH  = 32;
    localparam int ACC_W       = 2 * ELEM_WIDTH + 2;
    localparam int ITEM_TARGET = 370;
    localparam int TAIL_CYCLES = 40;

    localparam action_t ACT_UNUSED = action_t'(2'd3);

    localparam logic signed [31:0] VAL_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_ONE     = 32'sh0001_0000;
    localparam logic signed [31:0] VAL_NEG_LSB = -32'sd1;

    localparam logic signed [ACC_W-1:0] ELEM_MAX = (ACC_W'(1) <<< (ELEM_WIDTH - 1)) - 1;
    localparam logic signed [ACC_W-1:0] ELEM_MIN = -ELEM_MAX - 1;

    logic clk;
    logic rst_n;

    mm4_in_if  cmd_bus ();
    mm4_out_if prod_bus ();

    matrix4_multiply #(
        .FRAC_BITS  (FRAC_BITS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .prod  (prod_bus)
    );

    // Local copy of both matrices, column-major, as the block should hold them.
    logic signed [ELEM_WIDTH-1:0] left_elems [16];
    logic signed [ELEM_WIDTH-1:0] right_elems [16];

    out_item_t expected_products [$];
    int        error_count = 0;
    int        items_taken = 0;
    bit        src_calm    = 1'b0;
    bit        sink_calm   = 1'b0;
    int        sink_hold   = 0;

    // Clock, 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Generous overall limit on the run.
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side back-pressure: mostly ready, short stalls, now and then a long one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            prod_bus.ready <= 1'b0;
        end
        else if (sink_hold > 0)
        begin
            sink_hold = sink_hold - 1;
            prod_bus.ready <= 1'b0;
        end
        else if (sink_calm || $urandom_range(0, 99) < 65)
        begin
            prod_bus.ready <= 1'b1;
        end
        else
        begin
            sink_hold = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                     : $urandom_range(11, 39);
            prod_bus.ready <= 1'b0;
        end
    end

    // Each accepted product element is compared with the oldest expected one.
    always @(posedge clk)
    begin : check_products
        out_item_t want;
        if (rst_n && prod_bus.valid && prod_bus.ready)
        begin
            if (expected_products.size() == 0)
            begin
                $display("%0t: unexpected product element, actual index %0d value %0d",
                         $time, prod_bus.data.prod_index, prod_bus.data.prod_value);
                error_count++;
            end
            else
            begin
                want = expected_products.pop_front();
                if (prod_bus.data.prod_index !== want.prod_index)
                begin
                    $display("%0t: prod_index expected %0d actual %0d",
                             $time, want.prod_index, prod_bus.data.prod_index);
                    error_count++;
                end
                if (prod_bus.data.prod_value !== want.prod_value)
                begin
                    $display("%0t: prod_value (index %0d) expected %h actual %h",
                             $time, want.prod_index, want.prod_value,
                             prod_bus.data.prod_value);
                    error_count++;
                end
                if (prod_bus.data.saturated !== want.saturated)
                begin
                    $display("%0t: saturated (index %0d) expected %b actual %b",
                             $time, want.prod_index, want.saturated,
                             prod_bus.data.saturated);
                    error_count++;
                end
                if (prod_bus.data.last !== want.last)
                begin
                    $display("%0t: last (index %0d) expected %b actual %b",
                             $time, want.prod_index, want.last, prod_bus.data.last);
                    error_count++;
                end
            end
        end
    end

    // Works out the sixteen elements of left times right and queues them.
    // Sums are kept exact, floored by the shift, then clipped to the element width.
    task automatic predict_products();
        logic signed [ACC_W-1:0]      acc;
        logic signed [ACC_W-1:0]      scaled;
        logic signed [ELEM_WIDTH-1:0] narrow;
        out_item_t                    res;
        for (int k = 0; k < 16; k++)
        begin
            acc = '0;
            for (int j = 0; j < 4; j++)
            begin
                acc = acc + left_elems[j * 4 + k % 4] * right_elems[(k / 4) * 4 + j];
            end
            scaled = acc >>> FRAC_BITS;
            res.saturated = 1'b1;
            if (scaled > ELEM_MAX)
                narrow = ELEM_MAX[ELEM_WIDTH-1:0];
            else if (scaled < ELEM_MIN)
                narrow = ELEM_MIN[ELEM_WIDTH-1:0];
            else
            begin
                narrow = scaled[ELEM_WIDTH-1:0];
                res.saturated = 1'b0;
            end
            res.prod_index = k[3:0];
            res.prod_value = narrow;
            res.last       = (k == 15);
            expected_products.push_back(res);
        end
    endtask

    // Gap before an item: none in calm stretches, else mostly short, rarely long.
    function automatic int pick_source_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (src_calm || roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return VAL_NEG_LSB;
            default: return VAL_ONE;
        endcase
    endfunction

    // Mostly small Q16.16 values so that sums stay in range; some raw and extreme ones.
    function automatic logic signed [31:0] pick_elem_value();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return pick_extreme();
            default: return 32'(int'($urandom_range(0, 524288)) - 262144);
        endcase
    endfunction

    // Sends one item and updates the local matrices or the expected products on
    // acceptance. Valid is left high so that the next item can follow at once.
    task automatic send_cmd(input action_t act, input logic [3:0] idx,
                            input logic signed [31:0] value);
        int gap;
        gap = pick_source_gap();
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid           <= 1'b1;
        cmd_bus.data.action     <= act;
        cmd_bus.data.elem_index <= idx;
        cmd_bus.data.elem_value <= value;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        case (act)
            ACT_WR_LEFT:
            begin
                left_elems[idx] = value[ELEM_WIDTH-1:0];
                items_taken++;
            end
            ACT_WR_RIGHT:
            begin
                right_elems[idx] = value[ELEM_WIDTH-1:0];
                items_taken++;
            end
            ACT_MULTIPLY:
            begin
                predict_products();
                items_taken++;
            end
            default:
            begin
                // The unused action code leaves the block untouched.
            end
        endcase
    endtask

    task automatic send_multiply();
        send_cmd(ACT_MULTIPLY, 4'($urandom), $urandom);
    endtask

    // Stops sending and waits until every expected product has come back.
    task automatic wait_for_products();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_products.size() != 0)
            @(posedge clk);
    endtask

    // Both matrices as the identity: every entry is written before any multiply.
    task automatic test_fill_identity();
        for (int i = 0; i < 16; i++)
            send_cmd(ACT_WR_LEFT, 4'(i), (i % 5 == 0) ? VAL_ONE : 32'sd0);
        for (int i = 15; i >= 0; i--)
            send_cmd(ACT_WR_RIGHT, 4'(i), (i % 5 == 0) ? VAL_ONE : 32'sd0);
        send_multiply();
    endtask

    // Positive overflow from min times min and max times max, negative from min times max.
    task automatic test_saturation();
        send_cmd(ACT_WR_LEFT, 4'd0, VAL_MIN);
        send_cmd(ACT_WR_RIGHT, 4'd0, VAL_MIN);
        send_cmd(ACT_WR_RIGHT, 4'd4, VAL_MAX);
        send_cmd(ACT_WR_LEFT, 4'd15, VAL_MAX);
        send_cmd(ACT_WR_RIGHT, 4'd15, VAL_MAX);
        send_multiply();
    endtask

    // Results that land exactly on the limits, and a negative sum that rounds down.
    task automatic test_exact_limits();
        send_cmd(ACT_WR_LEFT, 4'd0, VAL_MAX);
        send_cmd(ACT_WR_RIGHT, 4'd0, VAL_ONE);
        send_cmd(ACT_WR_LEFT, 4'd1, VAL_MIN);
        send_cmd(ACT_WR_RIGHT, 4'd15, VAL_NEG_LSB);
        send_multiply();
    endtask

    // Items with the unused action code must change nothing. The sender then
    // holds off until all products are in, and multiplies again.
    task automatic test_unused_action();
        send_cmd(ACT_UNUSED, 4'd0, 32'sd0);
        send_cmd(ACT_UNUSED, 4'd15, VAL_MAX);
        send_multiply();
        wait_for_products();
        send_multiply();
    endtask

    // Random sequences, mostly a few writes followed by a multiply.
    task automatic test_random_sequences();
        int       kind;
        bit       to_left;
        while (items_taken < ITEM_TARGET)
        begin
            src_calm  = ($urandom_range(0, 5) == 0);
            sink_calm = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                repeat ($urandom_range(1, 6))
                    send_cmd(($urandom_range(0, 1) == 0) ? ACT_WR_LEFT : ACT_WR_RIGHT,
                             4'($urandom), pick_elem_value());
                send_multiply();
            end
            else if (kind < 78)
            begin
                // Whole matrix rewritten with many extremes: stresses the wide sum.
                to_left = ($urandom_range(0, 1) == 1);
                for (int i = 0; i < 16; i++)
                    send_cmd(to_left ? ACT_WR_LEFT : ACT_WR_RIGHT, 4'(i),
                             ($urandom_range(0, 1) == 0) ? pick_extreme()
                                                         : pick_elem_value());
                send_multiply();
            end
            else if (kind < 88)
            begin
                repeat ($urandom_range(1, 4))
                    send_cmd(($urandom_range(0, 1) == 0) ? ACT_WR_LEFT : ACT_WR_RIGHT,
                             4'($urandom), pick_elem_value());
            end
            else if (kind < 93)
            begin
                repeat ($urandom_range(1, 2))
                    send_cmd(ACT_UNUSED, 4'($urandom), $urandom);
            end
            else
            begin
                send_multiply();
                send_multiply();
            end
            if ($urandom_range(0, 9) == 0)
                wait_for_products();
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n            <= 1'b0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.data     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_identity();
        test_saturation();
        test_exact_limits();
        test_unused_action();
        test_random_sequences();

        wait_for_products();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mm4_pkg.sv
hw/rtl/mm4_if.sv
hw/rtl/mm4_store.sv
hw/rtl/mm4_dot.sv
hw/rtl/matrix4_multiply.sv
sim/matrix4_multiply_tb.sv
